// ===== rtl/dta_pkg.sv =====
`default_nettype none

package dta_pkg;

    // Quotient bits kept by the serial divider; higher bits only set the overflow flag.
    localparam int QUO_BITS = 17;

    // 1320 * 16 scaling of the sensor ratio, and its width.
    localparam int SCALE_BITS = 15;
    localparam logic [SCALE_BITS-1:0] SCALE_NUM = 15'd21120;

    // 279 degC in 1/16 steps, the fault code (-999 degC) and the positive limit.
    localparam logic signed [17:0] TEMP_OFFSET = 18'sd4464;
    localparam logic signed [17:0] TEMP_MAX    = 18'sd32767;
    localparam logic [15:0]        TEMP_ERROR  = 16'hC190;
    localparam logic [15:0]        TEMP_SAT    = 16'h7FFF;

    // Register word index on the configuration port.
    typedef enum logic [1:0] {
        REG_FILTER_ON       = 2'd0,
        REG_WINDOW_LENGTH   = 2'd1,
        REG_REFERENCE_CAL   = 2'd2
    } reg_index_t;

    // Divider result handed back to the sequencer.
    typedef struct packed {
        logic [QUO_BITS-1:0] quo;
        logic                ovf;
        logic                rem_nz;
    } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/dta_ram.sv =====
`default_nettype none

module dta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/dta_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, numerator fed MSB first.
module dta_div
    import dta_pkg::*;
#(
    parameter int NUM_BITS  = 39,
    parameter int DEN_BITS  = 24,
    parameter int STEP_BITS = 6
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [NUM_BITS-1:0]  num,
    input  wire logic [DEN_BITS-1:0]  den,
    input  wire logic [STEP_BITS-1:0] steps,
    output logic                      busy,
    output logic                      done,
    output div_res_t                  res
);

    logic [NUM_BITS-1:0]  num_reg;
    logic [DEN_BITS-1:0]  den_reg;
    logic [DEN_BITS-1:0]  rem_reg;
    logic [QUO_BITS-1:0]  quo_reg;
    logic                 ovf_reg;
    logic [STEP_BITS-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DEN_BITS:0]    trial;
    logic [DEN_BITS:0]    diff;
    logic                 ge;

    always_comb begin
        trial = {rem_reg, num_reg[NUM_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == STEP_BITS'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_BITS'(1);
                if (cnt_reg == STEP_BITS'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
            rem_reg <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            quo_reg <= {quo_reg[QUO_BITS-2:0], ge};
            ovf_reg <= ovf_reg | quo_reg[QUO_BITS-1];
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign res.quo    = quo_reg;
    assign res.ovf    = ovf_reg;
    assign res.rem_nz = |rem_reg;

endmodule

`default_nettype wire

// ===== rtl/die_temperature_average.sv =====
`default_nettype none

// Channel  Dir  Payload                                                        Handshake
// s_       in   tdata: reference_reading, sensor_reading; tuser: fault flag    tvalid/tready
// m_       out  tdata: temperature (1/16 degC, signed); tuser: error           tvalid/tready
// APB      in   filter_on @0x0, window_length @0x4, reference_cal @0x8         pready tied high
//
// A faulted request or a zero reference goes from idle through the final state to the
// output register. A converted request runs READING_BITS shift-add steps, then
// 2*READING_BITS+15 divider steps (one quotient bit a cycle). With averaging the store
// walk reads each filled entry through the RAM read port, and the mean takes
// 16+log2(MAX_WINDOW) more divider steps.
// Reset (aresetn low, synchronous) restores the control and configuration registers and empties the store.
// s_tready is high only between requests; a finished result waits in the output
// register while the next request is taken, and the last state holds while it is full.
module die_temperature_average
    import dta_pkg::*;
#(
    parameter int MAX_WINDOW   = 32,
    parameter int READING_BITS = 12
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // [RB-1:0] reference_reading, [2RB-1:RB] sensor_reading, zero pad to bytes
    input  wire logic [((2*READING_BITS+7)/8)*8-1:0]   s_tdata,
    // [0] conversion_fault
    input  wire logic                                  s_tuser,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // [15:0] temperature
    output logic [15:0]                                m_tdata,
    // [0] error
    output logic                                       m_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [3:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    localparam int RB        = READING_BITS;
    localparam int NUM_BITS  = 2*RB + SCALE_BITS;
    localparam int DEN_BITS  = 2*RB;
    localparam int K_BITS    = RB + SCALE_BITS;
    localparam int AW        = $clog2(MAX_WINDOW);
    localparam int CW        = $clog2(MAX_WINDOW + 1);
    localparam int CMP_BITS  = (CW > 6) ? CW : 6;
    localparam int SUM_BITS  = 16 + AW;
    localparam int STEP_BITS = $clog2(NUM_BITS + 1);
    localparam int MC_BITS   = $clog2(RB + 1);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_MUL     = 8'b0000_0010,
        ST_DIV1    = 8'b0000_0100,
        ST_UPDATE  = 8'b0000_1000,
        ST_WALK    = 8'b0001_0000,
        ST_SUMLAST = 8'b0010_0000,
        ST_MDIV    = 8'b0100_0000,
        ST_FIN     = 8'b1000_0000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic          filter_on_reg;
    logic [5:0]    window_length_reg;
    logic [RB-1:0] ref_cal_reg;
    logic          cfg_write;

    // Datapath registers.
    logic [NUM_BITS-1:0] acc_mul_reg;
    logic [NUM_BITS-1:0] mcand_reg;
    logic [RB-1:0]       mplier_reg;
    logic [MC_BITS-1:0]  mul_cnt_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [15:0]         sample_reg;
    logic [15:0]         res_temp_reg;
    logic                res_err_reg;
    logic                div_start_reg;

    // Store bookkeeping.
    logic [AW-1:0]         write_slot_reg;
    logic [CW-1:0]         filled_count_reg;
    logic [MAX_WINDOW-1:0] valid_reg;
    logic [AW-1:0]         idx_reg;
    logic                  rdv_reg;
    logic                  valid_rd_reg;
    logic signed [SUM_BITS-1:0] sum_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [15:0] m_temp_reg;
    logic        m_err_reg;

    // Combinational helpers.
    logic [RB-1:0]        in_ref;
    logic [RB-1:0]        in_sen;
    logic [K_BITS-1:0]    k_val;
    logic [CMP_BITS-1:0]  wl_ext;
    logic [CW-1:0]        win;
    logic [AW-1:0]        slot;
    logic [CW:0]          slot_inc;
    logic [CW:0]          filled_inc;
    logic                 do_filter;
    logic signed [17:0]   sample_wide;
    logic [15:0]          sample16;
    logic [SUM_BITS-1:0]  abs_sum;
    logic [17:0]          qv;
    logic [17:0]          mean_wide;
    logic [15:0]          ram_rdata;
    logic                 ram_we;
    logic                 out_free;

    logic [NUM_BITS-1:0]  div_num;
    logic [DEN_BITS-1:0]  div_den;
    logic [STEP_BITS-1:0] div_steps;
    logic                 div_busy;
    logic                 div_done;
    div_res_t             div_res;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_on_reg     <= 1'b1;
            window_length_reg <= 6'd8;
            ref_cal_reg       <= RB'(1500);
        end else if (cfg_write) begin
            case (reg_index_t'(paddr[3:2]))
                REG_FILTER_ON:     filter_on_reg     <= pwdata[0];
                REG_WINDOW_LENGTH: window_length_reg <= pwdata[5:0];
                REG_REFERENCE_CAL: ref_cal_reg       <= pwdata[RB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index_t'(paddr[3:2]))
            REG_FILTER_ON:     prdata = {31'd0, filter_on_reg};
            REG_WINDOW_LENGTH: prdata = {26'd0, window_length_reg};
            REG_REFERENCE_CAL: prdata = 32'(ref_cal_reg);
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- combinational helpers ----------------
    assign in_ref = s_tdata[RB-1:0];
    assign in_sen = s_tdata[2*RB-1:RB];
    assign k_val  = K_BITS'(ref_cal_reg) * K_BITS'(SCALE_NUM);

    // Clamp the window into 1..MAX_WINDOW.
    always_comb begin
        wl_ext = CMP_BITS'(window_length_reg);
        if (wl_ext == '0) begin
            win = CW'(1);
        end else if (wl_ext > CMP_BITS'(MAX_WINDOW)) begin
            win = CW'(MAX_WINDOW);
        end else begin
            win = wl_ext[CW-1:0];
        end
        do_filter = filter_on_reg && (win > CW'(1));
    end

    // Slot and fill count after a store write; a stale slot past the window restarts at 0.
    always_comb begin
        slot       = (CW'(write_slot_reg) < win) ? write_slot_reg : '0;
        slot_inc   = (CW+1)'(slot) + (CW+1)'(1);
        filled_inc = (CW+1)'(filled_count_reg) + (CW+1)'(1);
    end

    // Offset and saturate the converted quotient.
    always_comb begin
        sample_wide = $signed({1'b0, div_res.quo}) - TEMP_OFFSET;
        if (div_res.ovf || (sample_wide > TEMP_MAX)) begin
            sample16 = TEMP_SAT;
        end else begin
            sample16 = sample_wide[15:0];
        end
    end

    // Floor mean: divide the magnitude, then round a negative quotient down.
    always_comb begin
        abs_sum = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
        qv      = {1'b0, div_res.quo};
        if (sum_reg[SUM_BITS-1]) begin
            mean_wide = (~qv + 18'd1) - 18'(div_res.rem_nz);
        end else begin
            mean_wide = qv;
        end
    end

    // Share the divider between conversion and mean.
    always_comb begin
        if (state_reg == ST_MDIV) begin
            div_num   = {abs_sum, (NUM_BITS-SUM_BITS)'(0)};
            div_den   = DEN_BITS'(filled_count_reg);
            div_steps = STEP_BITS'(SUM_BITS);
        end else begin
            div_num   = acc_mul_reg;
            div_den   = den_reg;
            div_steps = STEP_BITS'(NUM_BITS);
        end
    end

    dta_div #(
        .NUM_BITS  (NUM_BITS),
        .DEN_BITS  (DEN_BITS),
        .STEP_BITS (STEP_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num),
        .den     (div_den),
        .steps   (div_steps),
        .busy    (div_busy),
        .done    (div_done),
        .res     (div_res)
    );

    assign ram_we = (state_reg == ST_UPDATE);

    dta_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (sample_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // ---------------- sequencer and control state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            mul_cnt_reg      <= '0;
            div_start_reg    <= 1'b0;
            write_slot_reg   <= '0;
            filled_count_reg <= '0;
            valid_reg        <= '0;
            idx_reg          <= '0;
            rdv_reg          <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            // Start the divider after the last multiplier step and after the last entry.
            div_start_reg <= ((state_reg == ST_MUL) && (mul_cnt_reg == MC_BITS'(1))) ||
                             (state_reg == ST_SUMLAST);
            rdv_reg       <= (state_reg == ST_WALK);
            if ((state_reg == ST_FIN) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        // Drop a faulted or zero-reference request straight to the output.
                        if (s_tuser || (in_ref == '0)) begin
                            state_reg <= ST_FIN;
                        end else begin
                            mul_cnt_reg <= MC_BITS'(RB);
                            state_reg   <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    mul_cnt_reg <= mul_cnt_reg - MC_BITS'(1);
                    if (mul_cnt_reg == MC_BITS'(1)) begin
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        state_reg <= do_filter ? ST_UPDATE : ST_FIN;
                    end
                end
                ST_UPDATE: begin
                    valid_reg[slot] <= 1'b1;
                    write_slot_reg  <= (slot_inc == (CW+1)'(win)) ? '0 : slot_inc[AW-1:0];
                    filled_count_reg <= (filled_inc < (CW+1)'(win)) ?
                                        filled_inc[CW-1:0] : win;
                    idx_reg   <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK: begin
                    if (CW'(idx_reg) == filled_count_reg - CW'(1)) begin
                        state_reg <= ST_SUMLAST;
                    end else begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                ST_SUMLAST: begin
                    state_reg <= ST_MDIV;
                end
                ST_MDIV: begin
                    if (div_done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // Hold the result until the output register is free.
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        valid_rd_reg <= valid_reg[idx_reg];
        case (state_reg)
            ST_IDLE: begin
                res_temp_reg <= TEMP_ERROR;
                res_err_reg  <= 1'b1;
                acc_mul_reg  <= '0;
                mcand_reg    <= NUM_BITS'(k_val);
                mplier_reg   <= in_sen;
                den_reg      <= {in_ref, RB'(0)} - DEN_BITS'(in_ref);
            end
            ST_MUL: begin
                // Advance one multiplier bit: add the shifted multiplicand when set.
                if (mplier_reg[0]) begin
                    acc_mul_reg <= acc_mul_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[NUM_BITS-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[RB-1:1]};
            end
            ST_DIV1: begin
                if (div_done) begin
                    sample_reg   <= sample16;
                    res_temp_reg <= sample16;
                    res_err_reg  <= 1'b0;
                end
            end
            ST_UPDATE: begin
                sum_reg <= '0;
            end
            ST_MDIV: begin
                if (div_done) begin
                    res_temp_reg <= mean_wide[15:0];
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_temp_reg <= res_temp_reg;
                    m_err_reg  <= res_err_reg;
                end
            end
            default: ;
        endcase
        // Accumulate store entries in the cycle after their read address; empty slots are skipped.
        if (rdv_reg && valid_rd_reg) begin
            sum_reg <= sum_reg + SUM_BITS'($signed(ram_rdata));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_temp_reg;
    assign m_tuser  = m_err_reg;

    // ---------------- assertions ----------------
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("divider busy while taking a new request");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_count_reg <= CW'(MAX_WINDOW))
        else $error("fill count beyond store depth");

    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the final state");

    a_accept_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer stayed idle after a request");

endmodule

`default_nettype wire

// ===== sim/die_temperature_average_check.sv =====
`timescale 1ns / 1ps

module die_temperature_average_check
    import dta_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending_count
);

    localparam int unsigned        WINDOW_MAX   = 32;
    localparam longint unsigned    RATIO_SCALE  = 64'd21120;
    localparam longint unsigned    FULL_SCALE   = 64'd4095;
    localparam longint             KELVIN_SHIFT = 64'sd4464;
    localparam logic signed [15:0] FAULT_TEMP   = -16'sd15984;

    typedef struct {
        logic [15:0] temperature;
        logic        error;
    } temp_result_t;

    temp_result_t       temperature_queue[$];

    logic               filter_on_q;
    logic [5:0]         window_q;
    logic [11:0]        ref_cal_q;
    logic signed [15:0] sample_ram [0:WINDOW_MAX-1];
    int unsigned        wr_slot;
    int unsigned        fill_cnt;

    // One sample in 1/16 degC, saturated to 16 bits.
    function automatic logic signed [15:0] convert_sample(input logic [11:0] ref_cnt,
                                                          input logic [11:0] sen_cnt,
                                                          input logic [11:0] cal_cnt);
        longint unsigned num;
        longint unsigned den;
        longint          q;
        num = 64'(sen_cnt);
        num = num * 64'(cal_cnt) * RATIO_SCALE;
        den = 64'(ref_cnt);
        den = den * FULL_SCALE;
        q = num / den;
        q = q - KELVIN_SHIFT;
        if (q > 32767) return 16'sh7FFF;
        if (q < -32768) return 16'sh8000;
        return q[15:0];
    endfunction

    task automatic predict_temperature(input logic [11:0] ref_cnt,
                                       input logic [11:0] sen_cnt,
                                       input logic        fault);
        temp_result_t       r;
        logic signed [15:0] sample;
        int unsigned        win;
        int unsigned        slot;
        longint             acc;
        longint             quo;
        if (fault || ref_cnt == 12'd0) begin
            r.temperature = FAULT_TEMP;
            r.error       = 1'b1;
        end else begin
            sample = convert_sample(ref_cnt, sen_cnt, ref_cal_q);
            win = 32'(window_q);
            if (win == 0) win = 1;
            if (win > WINDOW_MAX) win = WINDOW_MAX;
            if (filter_on_q && win > 1) begin
                slot = (wr_slot < win) ? wr_slot : 0;
                sample_ram[slot] = sample;
                wr_slot  = (slot + 1) % win;
                fill_cnt = (fill_cnt + 1 < win) ? fill_cnt + 1 : win;
                acc = 0;
                for (int i = 0; i < fill_cnt; i++) acc += sample_ram[i];
                // floor toward minus infinity
                quo = acc / longint'(fill_cnt);
                if ((acc % longint'(fill_cnt)) != 0 && acc < 0) quo = quo - 1;
                r.temperature = quo[15:0];
            end else begin
                r.temperature = sample;
            end
            r.error = 1'b0;
        end
        temperature_queue.push_back(r);
    endtask

    always @(posedge aclk) begin : watch
        temp_result_t want;
        if (!aresetn) begin
            filter_on_q = 1'b1;
            window_q    = 6'd8;
            ref_cal_q   = 12'd1500;
            for (int i = 0; i < WINDOW_MAX; i++) sample_ram[i] = '0;
            wr_slot  = 0;
            fill_cnt = 0;
            temperature_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[3:2]))
                    REG_FILTER_ON:     filter_on_q = pwdata[0];
                    REG_WINDOW_LENGTH: window_q    = pwdata[5:0];
                    REG_REFERENCE_CAL: ref_cal_q   = pwdata[11:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_temperature(s_tdata[11:0], s_tdata[23:12], s_tuser);
            if (m_tvalid && m_tready) begin
                if (temperature_queue.size() == 0) begin
                    $error("unexpected result: temperature %0d error %0b",
                           $signed(m_tdata), m_tuser);
                    fail_count++;
                end else begin
                    want = temperature_queue.pop_front();
                    if (m_tdata !== want.temperature) begin
                        $error("temperature: expected %0d, actual %0d",
                               $signed(want.temperature), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser !== want.error) begin
                        $error("error: expected %0b, actual %0b", want.error, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
        pending_count <= temperature_queue.size();
    end

endmodule

// ===== sim/die_temperature_average_test.sv =====
`timescale 1ns / 1ps

module die_temperature_average_test;
    import dta_pkg::*;

    // Worst case is a full averaging pass plus the longest idle gap on each side per request.
    localparam int unsigned CYCLE_LIMIT  = 1_200_000;
    localparam int          RANDOM_ITEMS = 1850;
    // Quiet time after the last result, enough for a full averaging pass.
    localparam int          TAIL_CYCLES  = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire  logic  s_tready;
    wire  logic [15:0] m_tdata;
    wire  logic  m_tuser;
    wire  logic  m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire  logic [31:0] prdata;
    wire  logic  pready;

    int          fail_count;
    int          pending_count;

    // Longest idle stretch per side; zero gives back-to-back traffic.
    int          tx_max = 0;
    int          rx_max = 0;
    int unsigned cycle_cnt = 0;
    int          stall_left = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    die_temperature_average dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    die_temperature_average_check check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: after each accepted result, drop tready for a random stretch,
    // so the stall overlaps whatever the block is doing next.
    always @(posedge aclk) begin : result_sink
        int hold;
        if (m_tvalid && m_tready) begin
            hold = $urandom_range(0, rx_max);
            if (hold != 0) begin
                m_tready   <= 1'b0;
                stall_left <= hold;
            end
        end else if (!m_tready) begin
            if (stall_left <= 1) m_tready <= 1'b1;
            else stall_left <= stall_left - 1;
        end
    end

    // Two-phase register write; leave the bus idle afterwards.
    task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Present one request after a random gap and hold it until accepted.
    // With no gap, tvalid simply stays high into the next request.
    task automatic send_reading(input logic [11:0] ref_cnt,
                                input logic [11:0] sen_cnt,
                                input logic        fault);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {sen_cnt, ref_cnt};
        s_tuser  <= fault;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // Reconfigure only once the block has gone idle.
    task automatic configure_filter(input logic       filter,
                                    input logic [5:0] window,
                                    input logic [11:0] cal);
        drain_results();
        apb_write(REG_FILTER_ON, {31'd0, filter});
        apb_write(REG_WINDOW_LENGTH, {26'd0, window});
        apb_write(REG_REFERENCE_CAL, {20'd0, cal});
    endtask

    // Mostly plausible readings near room temperature, plus faults, zero
    // references, saturating ratios and raw noise.
    task automatic send_random_reading();
        int          pick;
        logic [11:0] ref_cnt;
        logic [11:0] sen_cnt;
        logic        fault;
        pick    = $urandom_range(0, 99);
        ref_cnt = 12'($urandom_range(0, 4095));
        sen_cnt = 12'($urandom_range(0, 4095));
        fault   = 1'b0;
        if (pick < 65) begin
            ref_cnt = 12'($urandom_range(1100, 1900));
            sen_cnt = 12'($urandom_range(600, 1400));
        end else if (pick < 75) begin
            fault = 1'b1;
        end else if (pick < 80) begin
            ref_cnt = 12'd0;
            fault   = 1'($urandom_range(0, 1));
        end else if (pick < 87) begin
            ref_cnt = 12'($urandom_range(1, 8));
        end else if (ref_cnt == 12'd0) begin
            ref_cnt = 12'd1;
        end
        send_reading(ref_cnt, sen_cnt, fault);
    endtask

    initial begin : stimulus
        int          sent;
        int          phase_len;
        logic        filter;
        logic [5:0]  window;
        logic [11:0] cal;

        // Hold reset low from the start, then release it.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, starting from the reset settings (averaging over 8).
        tx_max = 12;
        rx_max = 12;
        send_reading(12'd4095, 12'd0, 1'b0);      // lowest possible sample
        send_reading(12'd1, 12'd4095, 1'b0);      // positive saturation
        send_reading(12'd1500, 12'd900, 1'b1);    // conversion fault
        send_reading(12'd0, 12'd2000, 1'b0);      // zero reference
        send_reading(12'd0, 12'd0, 1'b1);
        send_reading(12'd4095, 12'd4095, 1'b0);
        send_reading(12'd1, 12'd1, 1'b0);
        send_reading(12'd1500, 12'd1000, 1'b0);
        send_reading(12'd4095, 12'd1, 1'b0);      // near-lowest sample; the mean of the store stays positive

        // Window of one and window of zero both pass samples through.
        configure_filter(1'b1, 6'd1, 12'd1500);
        send_reading(12'd1600, 12'd950, 1'b0);
        send_reading(12'd4095, 12'd0, 1'b0);
        configure_filter(1'b1, 6'd0, 12'd1500);
        send_reading(12'd1234, 12'd2345, 1'b0);

        // Filter off with the widest window.
        configure_filter(1'b0, 6'd32, 12'd1500);
        send_reading(12'd1, 12'd4095, 1'b0);
        send_reading(12'd1500, 12'd1200, 1'b0);

        // Window above the limit clamps to the full store.
        configure_filter(1'b1, 6'd63, 12'd1500);
        send_reading(12'd1450, 12'd980, 1'b0);
        send_reading(12'd1550, 12'd1010, 1'b0);
        send_reading(12'd4095, 12'd0, 1'b0);
        send_reading(12'd1, 12'd4095, 1'b0);

        // Calibration extremes.
        configure_filter(1'b1, 6'd63, 12'd0);
        send_reading(12'd1500, 12'd1500, 1'b0);
        configure_filter(1'b1, 6'd63, 12'd4095);
        send_reading(12'd1, 12'd4095, 1'b0);
        send_reading(12'd4095, 12'd4095, 1'b0);

        // Shrink the window under the write slot and the filled count.
        configure_filter(1'b1, 6'd2, 12'd1500);
        send_reading(12'd1500, 12'd3000, 1'b0);
        send_reading(12'd2000, 12'd500, 1'b0);

        // Random phases, each with its own settings and idle pattern.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            filter = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 7))
                0:       window = 6'd0;
                1:       window = 6'd1;
                2:       window = 6'd2;
                3:       window = 6'd32;
                4:       window = 6'($urandom_range(33, 63));
                default: window = 6'($urandom_range(2, 31));
            endcase
            case ($urandom_range(0, 5))
                0:       cal = 12'd0;
                1:       cal = 12'd4095;
                2:       cal = 12'($urandom_range(0, 4095));
                default: cal = 12'($urandom_range(1300, 1700));
            endcase
            configure_filter(filter, window, cal);
            tx_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            rx_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            phase_len = $urandom_range(1, 120);
            repeat (phase_len) begin
                send_random_reading();
                sent++;
                // Occasionally let the pipeline run dry mid-phase.
                if ($urandom_range(0, 99) == 0) drain_results();
            end
        end

        // Wait for the last results, then watch for strays.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
